// File: src/oopms_pkg.sv
// Shared types, constants and saturating arithmetic for the Or-opt pair move search.
package oopms_pkg;

  localparam int CIRC_W = 7;
  localparam int COST_W = 62;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_CMP = 5'd18;
  localparam int MIN_TOUR = 6;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [1:0] OPN_TOUR   = 2'd0;
  localparam logic [1:0] OPN_DIST   = 2'd1;
  localparam logic [1:0] OPN_SUB    = 2'd2;
  localparam logic [1:0] OPN_SEARCH = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  position;
    logic [5:0]  second_index;
    logic [5:0]  vertex;
    logic [31:0] distance;
    logic [55:0] seq_cost;
    logic [39:0] seq_time;
    logic [6:0]  seq_width;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [5:0]        best_first;
    logic [5:0]        best_second;
    logic [COST_W-1:0] best_cost;
  } out_item_t;

  typedef struct packed {
    logic [55:0] cost;
    logic [39:0] tm;
    logic [6:0]  width;
  } sub_rec_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CLR   = 3'd1,
    OP_LOAD0 = 3'd2,
    OP_ADDE  = 3'd3,
    OP_MUL   = 3'd4,
    OP_ACCP  = 3'd5,
    OP_ACCS  = 3'd6,
    OP_CMP   = 3'd7
  } dp_op_t;

  typedef struct packed {
    logic       tour_rd;
    logic [1:0] tour_sel;
    logic       dist_rd;
    logic       cap_e;
    logic [1:0] e_sel;
    logic       sub_rd;
    logic [1:0] sub_sel;
    dp_op_t     op;
  } dp_cmd_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] sat_mul(input logic [6:0] w,
                                                input logic [COST_W-1:0] t);
    logic [COST_W+6:0] p;
    p = (COST_W + 7)'(w) * (COST_W + 7)'(t);
    return (p[COST_W+6:COST_W] != 7'd0) ? COST_MAX : p[COST_W-1:0];
  endfunction

endpackage

// File: src/oopms_ctrl.sv
// Controller: configuration register, move scan order and per-move step schedule.
module oopms_ctrl import oopms_pkg::*; #(
  parameter int MAX_TOUR = 64,
  parameter int AW = $clog2(MAX_TOUR)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        operation,
  input  logic              cfg_valid,
  input  logic [CIRC_W-1:0] cfg_data,
  output logic              cfg_ready,
  output logic              busy,
  output logic              out_valid,
  output dp_cmd_t           cmd,
  output logic [AW-1:0]     mv_i,
  output logic [AW-1:0]     mv_j,
  output logic              mv_dir,
  output logic [AW-1:0]     last
);

  localparam int NB = $clog2(MAX_TOUR + 1);
  localparam int NW = (NB > CIRC_W) ? NB : CIRC_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOVE = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [AW-1:0]      i_r, i_nxt, j_r, j_nxt, last_r, last_nxt;
  logic               dir_r, dir_nxt;
  logic [CIRC_W-1:0]  circ_r;
  logic [NW-1:0]      n_w;
  logic               fire;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign mv_i      = i_r;
  assign mv_j      = j_r;
  assign mv_dir    = dir_r;
  assign last      = last_r;
  assign fire      = start && (state_r == ST_IDLE);
  assign n_w = (NW'(circ_r) > NW'(MAX_TOUR)) ? NW'(MAX_TOUR) : NW'(circ_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    dir_nxt   = dir_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (fire && operation == OPN_SEARCH) begin
          cmd.op   = OP_CLR;
          last_nxt = AW'(n_w - NW'(2));
          step_nxt = '0;
          i_nxt    = AW'(1);
          j_nxt    = AW'(3);
          dir_nxt  = 1'b0;
          state_nxt = (n_w < NW'(MIN_TOUR)) ? ST_DONE : ST_MOVE;
        end
      end
      ST_MOVE: begin
        step_nxt = step_r + STEP_W'(1);
        case (step_r)
          5'd0: begin
            cmd.tour_rd = 1'b1; cmd.tour_sel = 2'd0;
          end
          5'd1: begin
            cmd.dist_rd = 1'b1; cmd.tour_rd = 1'b1; cmd.tour_sel = 2'd1;
          end
          5'd2: begin
            cmd.cap_e = 1'b1; cmd.e_sel = 2'd0; cmd.dist_rd = 1'b1;
            cmd.tour_rd = 1'b1; cmd.tour_sel = 2'd2;
          end
          5'd3: begin
            cmd.cap_e = 1'b1; cmd.e_sel = 2'd1; cmd.dist_rd = 1'b1;
          end
          5'd4: begin
            cmd.cap_e = 1'b1; cmd.e_sel = 2'd2; cmd.sub_rd = 1'b1; cmd.sub_sel = 2'd0;
          end
          5'd5: begin
            cmd.op = OP_LOAD0; cmd.sub_rd = 1'b1; cmd.sub_sel = 2'd1;
          end
          5'd6: begin
            cmd.op = OP_ADDE; cmd.e_sel = 2'd0;
          end
          5'd7: cmd.op = OP_MUL;
          5'd8: cmd.op = OP_ACCP;
          5'd9: begin
            cmd.op = OP_ACCS; cmd.sub_rd = 1'b1; cmd.sub_sel = 2'd2;
          end
          5'd10: begin
            cmd.op = OP_ADDE; cmd.e_sel = 2'd1;
          end
          5'd11: cmd.op = OP_MUL;
          5'd12: cmd.op = OP_ACCP;
          5'd13: begin
            cmd.op = OP_ACCS; cmd.sub_rd = 1'b1; cmd.sub_sel = 2'd3;
          end
          5'd14: begin
            cmd.op = OP_ADDE; cmd.e_sel = 2'd2;
          end
          5'd15: cmd.op = OP_MUL;
          5'd16: cmd.op = OP_ACCP;
          5'd17: cmd.op = OP_ACCS;
          default: cmd.op = OP_NONE;
        endcase
        if (step_r == STEP_CMP) begin
          cmd.op   = OP_CMP;
          step_nxt = '0;
          if (!dir_r) begin
            if (j_r != last_r) begin
              j_nxt = j_r + AW'(1);
            end else if ((AW+1)'(i_r) + (AW+1)'(3) < (AW+1)'(last_r)) begin
              i_nxt = i_r + AW'(1);
              j_nxt = i_r + AW'(3);
            end else begin
              dir_nxt = 1'b1;
              i_nxt   = AW'(3);
              j_nxt   = AW'(2);
            end
          end else begin
            if (j_r != AW'(1)) begin
              j_nxt = j_r - AW'(1);
            end else if ((AW+1)'(i_r) + (AW+1)'(1) < (AW+1)'(last_r)) begin
              i_nxt = i_r + AW'(1);
              j_nxt = i_r;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      circ_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        circ_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    dir_r  <= dir_nxt;
    last_r <= last_nxt;
  end

endmodule

// File: src/oopms_datapath.sv
// Datapath: tour, distance and subsequence memories with the saturating cost unit.
module oopms_datapath import oopms_pkg::*; #(
  parameter int MAX_TOUR = 64,
  parameter int AW = $clog2(MAX_TOUR)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_wr,
  input  in_item_t      in_data,
  input  dp_cmd_t       cmd,
  input  logic [AW-1:0] mv_i,
  input  logic [AW-1:0] mv_j,
  input  logic          mv_dir,
  input  logic [AW-1:0] last,
  output out_item_t     out_data
);

  localparam int DEPTH = MAX_TOUR * MAX_TOUR;
  localparam int DAW = $clog2(DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [5:0] v);
    logic [8:0] r;
    r = 9'(v);
    for (int k = 0; k < 8; k++) begin
      if (r >= 9'(MAX_TOUR)) r = r - 9'(MAX_TOUR);
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [DAW-1:0] sidx(input logic [AW-1:0] a, input logic [AW-1:0] b);
    return DAW'(a) * DAW'(MAX_TOUR) + DAW'(b);
  endfunction

  logic [5:0]        tour_mem [MAX_TOUR];
  logic [31:0]       dist_mem [DEPTH];
  sub_rec_t          sub_mem  [DEPTH];

  logic [5:0]        tva_r, tvb_r;
  logic [31:0]       dist_rd_r;
  sub_rec_t          sub_rd_r;
  logic [31:0]       e_r [4];
  logic [COST_W-1:0] t_r, total_r, prod_r, best_cost_r;
  logic [5:0]        best_i_r, best_j_r;
  logic              have_r;

  logic [AW-1:0]     seg_s [4];
  logic [AW-1:0]     seg_e [4];
  logic [AW-1:0]     edg_a [4];
  logic [AW-1:0]     edg_b [4];
  logic [AW-1:0]     i_m1, i_p1, i_p2, j_m1, j_p1, last_p1;

  assign i_m1    = mv_i - AW'(1);
  assign i_p1    = mv_i + AW'(1);
  assign i_p2    = mv_i + AW'(2);
  assign j_m1    = mv_j - AW'(1);
  assign j_p1    = mv_j + AW'(1);
  assign last_p1 = last + AW'(1);

  always_comb begin
    if (!mv_dir) begin
      seg_s[0] = '0;    seg_e[0] = i_m1;
      seg_s[1] = i_p2;  seg_e[1] = mv_j;
      seg_s[2] = mv_i;  seg_e[2] = i_p1;
      seg_s[3] = j_p1;  seg_e[3] = last_p1;
      edg_a[0] = i_m1;  edg_b[0] = i_p2;
      edg_a[1] = mv_j;  edg_b[1] = mv_i;
      edg_a[2] = i_p1;  edg_b[2] = j_p1;
    end else begin
      seg_s[0] = '0;    seg_e[0] = j_m1;
      seg_s[1] = mv_i;  seg_e[1] = i_p1;
      seg_s[2] = mv_j;  seg_e[2] = i_m1;
      seg_s[3] = i_p2;  seg_e[3] = last_p1;
      edg_a[0] = j_m1;  edg_b[0] = mv_i;
      edg_a[1] = i_p1;  edg_b[1] = mv_j;
      edg_a[2] = i_m1;  edg_b[2] = i_p2;
    end
    edg_a[3] = edg_a[2];
    edg_b[3] = edg_b[2];
  end

  always_ff @(posedge clk) begin
    if (in_wr && in_data.operation == OPN_TOUR) begin
      tour_mem[wrap(in_data.position)] <= in_data.vertex;
    end
    if (cmd.tour_rd) begin
      tva_r <= tour_mem[edg_a[cmd.tour_sel]];
      tvb_r <= tour_mem[edg_b[cmd.tour_sel]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_wr && in_data.operation == OPN_DIST) begin
      dist_mem[sidx(wrap(in_data.position), wrap(in_data.second_index))] <= in_data.distance;
    end
    if (cmd.dist_rd) begin
      dist_rd_r <= dist_mem[sidx(wrap(tva_r), wrap(tvb_r))];
    end
  end

  always_ff @(posedge clk) begin
    if (in_wr && in_data.operation == OPN_SUB) begin
      sub_mem[sidx(wrap(in_data.position), wrap(in_data.second_index))] <=
        '{cost: in_data.seq_cost, tm: in_data.seq_time, width: in_data.seq_width};
    end
    if (cmd.sub_rd) begin
      sub_rd_r <= sub_mem[sidx(seg_s[cmd.sub_sel], seg_e[cmd.sub_sel])];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_e) begin
      e_r[cmd.e_sel] <= dist_rd_r;
    end
    case (cmd.op)
      OP_LOAD0: begin
        total_r <= COST_W'(sub_rd_r.cost);
        t_r     <= COST_W'(sub_rd_r.tm);
      end
      OP_ADDE: t_r <= sat_add(t_r, COST_W'(e_r[cmd.e_sel]));
      OP_MUL:  prod_r <= sat_mul(sub_rd_r.width, t_r);
      OP_ACCP: total_r <= sat_add(total_r, prod_r);
      OP_ACCS: begin
        total_r <= sat_add(total_r, COST_W'(sub_rd_r.cost));
        t_r     <= sat_add(t_r, COST_W'(sub_rd_r.tm));
      end
      OP_CLR: begin
        best_cost_r <= '0;
        best_i_r    <= '0;
        best_j_r    <= '0;
      end
      OP_CMP: begin
        if (!have_r || total_r < best_cost_r) begin
          best_cost_r <= total_r;
          best_i_r    <= 6'(mv_i);
          best_j_r    <= 6'(mv_j);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (cmd.op == OP_CLR) begin
      have_r <= 1'b0;
    end else if (cmd.op == OP_CMP) begin
      have_r <= 1'b1;
    end
  end

  assign out_data.found       = have_r;
  assign out_data.best_first  = best_i_r;
  assign out_data.best_second = best_j_r;
  assign out_data.best_cost   = best_cost_r;

endmodule

// File: src/or_opt_pair_move_search_core.sv
// Top level of the Or-opt pair move search: controller, datapath and checks.
// Load beats (tour entry, distance, subsequence record) are taken one per cycle while
// busy is low and give no result. A search beat scans all two-vertex block moves;
// each move is scored in a schedule of read, load, add, multiply, accumulate and
// compare steps, set by the single-read distance and subsequence memories and the
// one shared saturating add and multiply unit. With L = circuit_length - 2 a search
// scores (L-2)(L-1)-2 moves before the result strobe; a tour shorter than six
// positions goes straight to the done state and answers with found low. busy is high
// for the whole search and the result is shown on out_data for exactly the one cycle that out_valid is high.
module or_opt_pair_move_search_core import oopms_pkg::*; #(
  parameter int MAX_TOUR = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIRC_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_TOUR);

  dp_cmd_t       cmd;
  logic [AW-1:0] mv_i, mv_j, last;
  logic          mv_dir;
  logic          in_wr;

  assign in_wr = start && !busy;

  oopms_ctrl #(.MAX_TOUR(MAX_TOUR), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_data.operation),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .mv_i      (mv_i),
    .mv_j      (mv_j),
    .mv_dir    (mv_dir),
    .last      (last)
  );

  oopms_datapath #(.MAX_TOUR(MAX_TOUR), .AW(AW)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_wr    (in_wr),
    .in_data  (in_data),
    .cmd      (cmd),
    .mv_i     (mv_i),
    .mv_j     (mv_j),
    .mv_dir   (mv_dir),
    .last     (last),
    .out_data (out_data)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe outside a search");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation == OPN_SEARCH) |=> busy)
    else $error("search beat did not start a search");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.best_cost == '0 &&
      out_data.best_first == '0 && out_data.best_second == '0))
    else $error("empty search result not cleared");

endmodule
